>>> hdl/yuv2rgb_pkg.sv
package yuv2rgb_pkg;

  // Chroma terms are scaled by this before the truncating divide.
  localparam int TERM_SCALE = 10000;

  // Signed chroma term; the widest one spans -226..225.
  typedef logic signed [8:0] term_t;
  typedef term_t term_table_t [256];

  // Placement of one 8-bit channel inside the 32-bit pixel word.
  typedef struct packed {
    logic       en;      // the channel contributes at all
    logic [2:0] rshift;  // drop this many low bits of the channel
    logic [4:0] lshift;  // bit position of the field's lowest bit
  } field_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  // Builds trunc(coef * (i - 128) / 10000) for every chroma byte i.
  // This is evaluated once at elaboration.
  function automatic term_table_t build_term(input int coef);
    term_table_t t;
    int          p;
    for (int i = 0; i < 256; i++) begin
      p = coef * (i - 128);
      t[i] = term_t'(p / TERM_SCALE);
    end
    return t;
  endfunction

  localparam term_table_t RED_TERM     = build_term(14013);
  localparam term_table_t GREEN_U_TERM = build_term(-3444);
  localparam term_table_t GREEN_V_TERM = build_term(-7136);
  localparam term_table_t BLUE_TERM    = build_term(17734);

endpackage

>>> hdl/yuv2rgb_chroma.sv
module yuv2rgb_chroma
  import yuv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] chroma_u,
  input  logic [7:0] chroma_v,
  output term_t      red_term,
  output term_t      green_term,
  output term_t      blue_term
);

  term_t green_sum;

  // Both green parts are truncated on their own before they are added.
  assign green_sum = GREEN_U_TERM[chroma_u] + GREEN_V_TERM[chroma_v];

  always_ff @(posedge clk) begin
    if (load) begin
      red_term   <= RED_TERM[chroma_v];
      green_term <= green_sum;
      blue_term  <= BLUE_TERM[chroma_u];
    end
  end

endmodule

>>> hdl/yuv2rgb_lane.sv
module yuv2rgb_lane
  import yuv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [7:0]  luma,
  input  term_t       red_term,
  input  term_t       green_term,
  input  term_t       blue_term,
  input  field_t      red_field,
  input  field_t      green_field,
  input  field_t      blue_field,
  output logic [31:0] pixel
);

  logic [31:0] red_word;
  logic [31:0] green_word;
  logic [31:0] blue_word;

  // Adds a term to luma, clamps to 0..255 and moves the top bits into place.
  function automatic logic [31:0] place(input logic [7:0] y, input term_t t,
                                        input field_t f);
    logic signed [9:0] level;
    logic [7:0]        c;
    logic [7:0]        kept;
    level = $signed({2'b00, y}) + 10'(t);
    if (level < 0) begin
      c = 8'd0;
    end else if (level > 10'sd255) begin
      c = 8'd255;
    end else begin
      c = level[7:0];
    end
    kept = c >> f.rshift;
    return f.en ? ({24'd0, kept} << f.lshift) : 32'd0;
  endfunction

  always_comb begin
    red_word   = place(luma, red_term, red_field);
    green_word = place(luma, green_term, green_field);
    blue_word  = place(luma, blue_term, blue_field);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel <= red_word | green_word | blue_word;
    end
  end

endmodule

>>> hdl/yuv420_to_packed_rgb.sv
// Converts one 2x2 block of 4:2:0 video per beat (four Y bytes and one shared
// U/V pair) into four packed 32-bit RGB pixels. The block takes one beat every
// clock cycle while the output does not stall; each result passes two registers:
// the first holds the chroma terms, which come from constant tables
// indexed by U and V, and the second holds the four pixels, each built by its
// own lane that adds the terms to its luma, clamps to 0..255 and places the
// top bits of each channel where the channel's mask says. A new beat is still
// taken while a finished result waits, but only while the first stage is empty.
// The mask registers sit on an APB port at byte addresses 0x0 (red), 0x4
// (green) and 0x8 (blue); write them only while the block is idle.
module yuv420_to_packed_rgb
  import yuv2rgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Input beat.
  input  logic         s_tvalid,
  output logic         s_tready,
  // luma_top_left[7:0], luma_top_right[15:8], luma_bottom_left[23:16],
  // luma_bottom_right[31:24], chroma_u[39:32], chroma_v[47:40]
  input  logic [47:0]  s_tdata,
  // Output beat.
  output logic         m_tvalid,
  input  logic         m_tready,
  // pixel_top_left[31:0], pixel_top_right[63:32], pixel_bottom_left[95:64],
  // pixel_bottom_right[127:96]
  output logic [127:0] m_tdata,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Decoded placement of the reset masks.
  localparam field_t RED_FIELD_RST   = '{en: 1'b1, rshift: 3'd0, lshift: 5'd16};
  localparam field_t GREEN_FIELD_RST = '{en: 1'b1, rshift: 3'd0, lshift: 5'd8};
  localparam field_t BLUE_FIELD_RST  = '{en: 1'b1, rshift: 3'd0, lshift: 5'd0};

  logic [31:0] red_mask;
  logic [31:0] green_mask;
  logic [31:0] blue_mask;
  field_t      red_field;
  field_t      green_field;
  field_t      blue_field;
  field_t      wr_field;
  logic        cfg_write;
  logic [1:0]  reg_index;

  logic        stage1_valid;
  logic [31:0] stage1_luma;
  logic        stage2_ready;
  term_t       red_term;
  term_t       green_term;
  term_t       blue_term;
  logic [31:0] pixel [4];

  // The mask is reduced to a width and a position when it is written, so the
  // pixel path only sees a small shift pair per channel. Only the number of
  // set bits and the lowest set bit matter; a mask of eight or more set bits
  // keeps the whole channel.
  function automatic field_t decode_mask(input logic [31:0] m);
    logic [5:0]  ones;
    logic [31:0] lowest;
    logic [4:0]  pos;
    field_t      f;
    ones   = 6'($countones(m));
    lowest = m & (~m + 32'd1);
    pos    = '0;
    for (int i = 0; i < 32; i++) begin
      if (lowest[i]) begin
        pos = pos | 5'(i);
      end
    end
    f.en     = (m != 32'd0);
    f.rshift = (ones >= 6'd8) ? 3'd0 : 3'(6'd8 - ones);
    f.lshift = pos;
    return f;
  endfunction

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign wr_field  = decode_mask(pwdata);

  always_comb begin
    unique case (reg_index)
      REG_RED:   prdata = red_mask;
      REG_GREEN: prdata = green_mask;
      REG_BLUE:  prdata = blue_mask;
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_mask    <= 32'h00FF_0000;
      green_mask  <= 32'h0000_FF00;
      blue_mask   <= 32'h0000_00FF;
      red_field   <= RED_FIELD_RST;
      green_field <= GREEN_FIELD_RST;
      blue_field  <= BLUE_FIELD_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_RED: begin
          red_mask  <= pwdata;
          red_field <= wr_field;
        end
        REG_GREEN: begin
          green_mask  <= pwdata;
          green_field <= wr_field;
        end
        REG_BLUE: begin
          blue_mask  <= pwdata;
          blue_field <= wr_field;
        end
        default: begin
        end
      endcase
    end
  end

  // Two-stage pipeline. Each stage loads when it is empty or when its
  // contents move on in the same cycle.
  assign stage2_ready = !m_tvalid || m_tready;
  assign s_tready     = !stage1_valid || stage2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (s_tready) begin
        stage1_valid <= s_tvalid;
      end
      if (stage2_ready) begin
        m_tvalid <= stage1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      stage1_luma <= s_tdata[31:0];
    end
  end

  // Chroma terms are shared by all four pixels of the block.
  yuv2rgb_chroma u_chroma (
    .clk        (clk),
    .load       (s_tready),
    .chroma_u   (s_tdata[39:32]),
    .chroma_v   (s_tdata[47:40]),
    .red_term   (red_term),
    .green_term (green_term),
    .blue_term  (blue_term)
  );

  // One lane per pixel of the block.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    yuv2rgb_lane u_lane (
      .clk         (clk),
      .load        (stage2_ready),
      .luma        (stage1_luma[8*k +: 8]),
      .red_term    (red_term),
      .green_term  (green_term),
      .blue_term   (blue_term),
      .red_field   (red_field),
      .green_field (green_field),
      .blue_field  (blue_field),
      .pixel       (pixel[k])
    );
  end

  // The lanes' words are merged into the output beat in block order.
  assign m_tdata = {pixel[3], pixel[2], pixel[1], pixel[0]};

  // A taken beat always occupies the first stage in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> stage1_valid)
    else $error("accepted beat did not reach the first stage");

  // A first-stage result that cannot move on keeps its chroma terms.
  assert property (@(posedge clk) disable iff (rst)
    (stage1_valid && !stage2_ready) |=>
      (stage1_valid && $stable(red_term) && $stable(green_term) &&
       $stable(blue_term) && $stable(stage1_luma)))
    else $error("stalled first stage lost its contents");

  // A stalled result at the output with a full first stage blocks input.
  assert property (@(posedge clk) disable iff (rst)
    (stage1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken with both stages full and stalled");

  // A write to the red register lands with its decoded placement.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_write && reg_index == REG_RED) |=>
      (red_mask == $past(pwdata) && red_field == $past(wr_field)))
    else $error("red mask write not applied");

  // Reset leaves both stages empty.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!stage1_valid && !m_tvalid))
    else $error("pipeline not empty after reset");

endmodule
